// File: sv/aapr_pkg.sv
// Shared types, register codes and tables for the axis-angle point rotator.
// Used by every other file of the block through scoped names.

package aapr_pkg;

	localparam int COEF_FRAC_BITS = 16;
	localparam int COORD_W        = 32;
	localparam int AXIS_W         = 16;
	localparam int ANGLE_W        = 16;
	localparam int CFG_IDX_W      = 4;
	localparam int CFG_DATA_W     = 16;
	localparam int CORDIC_W       = 32;
	localparam int CORDIC_STEPS   = 24;
	localparam int STEP_W         = 5;
	localparam int KIDX_W         = 4;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 32'sd652032874;
	localparam logic signed [CORDIC_W-1:0] Q30_ONE         = 32'sd1073741824;

	localparam logic [CFG_IDX_W-1:0] REG_ANGLE  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z = 4'd3;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rotated_x;
		logic signed [COORD_W-1:0] rotated_y;
		logic signed [COORD_W-1:0] rotated_z;
		logic                      saturated;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	// Recipe of one matrix coefficient: axis pair times (1 - c), plus c on the
	// diagonal or plus/minus an axis component times s elsewhere.
	typedef struct packed {
		logic [1:0] a;
		logic [1:0] b;
		logic [1:0] t;
		logic       diag;
		logic       neg;
	} coef_sel_t;

	function automatic coef_sel_t coef_sel(input logic [KIDX_W-1:0] k);
		coef_sel_t r;
		r = '{a: AX_X, b: AX_X, t: AX_X, diag: 1'b1, neg: 1'b0};
		unique case (k)
			4'd0: r = '{a: AX_X, b: AX_X, t: AX_X, diag: 1'b1, neg: 1'b0};
			4'd1: r = '{a: AX_X, b: AX_Y, t: AX_Z, diag: 1'b0, neg: 1'b0};
			4'd2: r = '{a: AX_X, b: AX_Z, t: AX_Y, diag: 1'b0, neg: 1'b1};
			4'd3: r = '{a: AX_X, b: AX_Y, t: AX_Z, diag: 1'b0, neg: 1'b1};
			4'd4: r = '{a: AX_Y, b: AX_Y, t: AX_X, diag: 1'b1, neg: 1'b0};
			4'd5: r = '{a: AX_Y, b: AX_Z, t: AX_X, diag: 1'b0, neg: 1'b0};
			4'd6: r = '{a: AX_X, b: AX_Z, t: AX_Y, diag: 1'b0, neg: 1'b0};
			4'd7: r = '{a: AX_Y, b: AX_Z, t: AX_X, diag: 1'b0, neg: 1'b1};
			4'd8: r = '{a: AX_Z, b: AX_Z, t: AX_X, diag: 1'b1, neg: 1'b0};
			default: r = '{a: AX_X, b: AX_X, t: AX_X, diag: 1'b1, neg: 1'b0};
		endcase
		return r;
	endfunction

	// Arctangent of 2^-i in units of 2^-32 turn.
	function automatic logic signed [CORDIC_W-1:0] atan_turns(input logic [STEP_W-1:0] i);
		logic signed [CORDIC_W-1:0] r;
		case (i)
			5'd0:  r = 32'sd536870912;
			5'd1:  r = 32'sd316933406;
			5'd2:  r = 32'sd167458907;
			5'd3:  r = 32'sd85004756;
			5'd4:  r = 32'sd42667331;
			5'd5:  r = 32'sd21354465;
			5'd6:  r = 32'sd10679838;
			5'd7:  r = 32'sd5340245;
			5'd8:  r = 32'sd2670163;
			5'd9:  r = 32'sd1335087;
			5'd10: r = 32'sd667544;
			5'd11: r = 32'sd333772;
			5'd12: r = 32'sd166886;
			5'd13: r = 32'sd83443;
			5'd14: r = 32'sd41722;
			5'd15: r = 32'sd20861;
			5'd16: r = 32'sd10430;
			5'd17: r = 32'sd5215;
			5'd18: r = 32'sd2608;
			5'd19: r = 32'sd1304;
			5'd20: r = 32'sd652;
			5'd21: r = 32'sd326;
			5'd22: r = 32'sd163;
			5'd23: r = 32'sd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/aapr_ifs.sv
// Valid/ready channel interfaces for points, results and configuration writes.
// Payload types come from aapr_pkg.

interface aapr_point_if;
	logic            valid;
	logic            ready;
	aapr_pkg::point_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface aapr_result_if;
	logic             valid;
	logic             ready;
	aapr_pkg::result_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface aapr_cfg_if;
	logic          valid;
	logic          ready;
	aapr_pkg::cfg_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

// File: sv/aapr_cordic.sv
// Iterative CORDIC giving the cosine and sine of a turn-fraction angle in Q1.30.
// One rotation step per cycle; uses the arctangent table of aapr_pkg.

module aapr_cordic (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	input  logic [aapr_pkg::ANGLE_W-1:0]           angle,
	output logic                                   done,
	output logic signed [aapr_pkg::CORDIC_W-1:0]   cos_val,
	output logic signed [aapr_pkg::CORDIC_W-1:0]   sin_val
);

	logic signed [aapr_pkg::CORDIC_W-1:0] x_q, y_q, z_q;
	logic signed [aapr_pkg::CORDIC_W-1:0] dx, dy;
	logic [aapr_pkg::STEP_W-1:0]          i_q;
	logic [1:0]                           quad_q;
	logic                                 run_q;
	logic                                 done_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				if (i_q == aapr_pkg::STEP_W'(aapr_pkg::CORDIC_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= aapr_pkg::CORDIC_GAIN_INV;
			y_q    <= '0;
			z_q    <= {2'b00, angle[aapr_pkg::ANGLE_W-3:0], 16'b0};
			quad_q <= angle[aapr_pkg::ANGLE_W-1 -: 2];
		end else if (run_q) begin
			if (!z_q[aapr_pkg::CORDIC_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - aapr_pkg::atan_turns(i_q);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + aapr_pkg::atan_turns(i_q);
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q;
				sin_val = y_q;
			end
			2'd1: begin
				cos_val = -y_q;
				sin_val = x_q;
			end
			2'd2: begin
				cos_val = -x_q;
				sin_val = -y_q;
			end
			default: begin
				cos_val = y_q;
				sin_val = -x_q;
			end
		endcase
	end

	assign done = done_q;

	a_done_timing: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##25 done_q)
		else $error("CORDIC result not ready after the fixed step count");

endmodule

// File: sv/aapr_coef.sv
// Configuration registers and the sequencer rebuilding the nine matrix
// coefficients after angle or axis writes. Uses aapr_cordic, aapr_pkg tables.

module aapr_coef #(
	parameter int COEF_FRAC_BITS = aapr_pkg::COEF_FRAC_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	aapr_cfg_if.sink                                cfg,
	output logic                                    busy,
	output logic [8:0][COEF_FRAC_BITS+1:0]          coef
);

	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int SHIFT  = 58 - COEF_FRAC_BITS;
	localparam int SH_W   = 64 - SHIFT;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_MUL1  = 3'd3;
	localparam logic [2:0] ST_MUL2  = 3'd4;
	localparam logic [2:0] ST_ACC   = 3'd5;

	localparam logic signed [63:0]     HALF    = 64'sd1 <<< (SHIFT - 1);
	localparam logic [COEF_W-1:0]      ONE     = COEF_W'(1) << COEF_FRAC_BITS;
	localparam logic [COEF_W-1:0]      ZERO    = '0;
	localparam logic [COEF_W-1:0]      COEF_MX = {1'b0, {(COEF_W-1){1'b1}}};
	localparam logic [COEF_W-1:0]      COEF_MN = {1'b1, {(COEF_W-1){1'b0}}};
	localparam logic [8:0][COEF_W-1:0] IDENT   =
		{ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE};

	logic [2:0]                              state_q;
	logic [aapr_pkg::KIDX_W-1:0]             k_q;
	logic [aapr_pkg::ANGLE_W-1:0]            angle_q;
	logic signed [aapr_pkg::AXIS_W-1:0]      axis_q [3];
	logic [8:0][COEF_W-1:0]                  coef_q;

	logic                                    cfg_wr;
	logic                                    cordic_start;
	logic                                    cordic_done;
	logic signed [aapr_pkg::CORDIC_W-1:0]    cos_val, sin_val;

	logic signed [aapr_pkg::CORDIC_W-1:0]    c_q, s_q;
	logic signed [aapr_pkg::CORDIC_W:0]      omc_q;
	logic signed [31:0]                      pair_q;
	logic signed [47:0]                      side_q;
	logic signed [63:0]                      prod_q, extra_q;
	logic signed [64:0]                      prod_full;
	logic signed [63:0]                      side_ext, side_sh, sum;
	logic signed [SH_W-1:0]                  sh;
	logic [COEF_W-1:0]                       coef_new;
	aapr_pkg::coef_sel_t                     sel;

	assign cfg_wr       = cfg.valid && cfg.ready;
	assign cfg.ready    = (state_q == ST_IDLE);
	assign busy         = (state_q != ST_IDLE);
	assign cordic_start = (state_q == ST_START);
	assign sel          = aapr_pkg::coef_sel(k_q);

	aapr_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cordic_start),
		.angle   (angle_q),
		.done    (cordic_done),
		.cos_val (cos_val),
		.sin_val (sin_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			k_q       <= '0;
			angle_q   <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= 16'sd16384;
			coef_q    <= IDENT;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_wr) begin
						unique case (cfg.payload.index)
							aapr_pkg::REG_ANGLE: begin
								angle_q <= cfg.payload.value;
								state_q <= ST_START;
							end
							aapr_pkg::REG_AXIS_X: begin
								axis_q[0] <= cfg.payload.value;
								state_q   <= ST_START;
							end
							aapr_pkg::REG_AXIS_Y: begin
								axis_q[1] <= cfg.payload.value;
								state_q   <= ST_START;
							end
							aapr_pkg::REG_AXIS_Z: begin
								axis_q[2] <= cfg.payload.value;
								state_q   <= ST_START;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_START: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (cordic_done) begin
						state_q <= ST_MUL1;
						k_q     <= '0;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= ST_ACC;
				ST_ACC: begin
					coef_q[k_q] <= coef_new;
					if (k_q == aapr_pkg::KIDX_W'(8)) begin
						state_q <= ST_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_MUL1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign prod_full = pair_q * omc_q;
	assign side_ext  = 64'(side_q);
	assign side_sh   = sel.diag ? (side_ext <<< 28) : (side_ext <<< 14);
	assign sum       = prod_q + extra_q;
	assign sh        = sum[63:SHIFT];

	always_comb begin
		if (&sh[SH_W-1:COEF_W-1] || ~|sh[SH_W-1:COEF_W-1]) begin
			coef_new = sh[COEF_W-1:0];
		end else if (sh[SH_W-1]) begin
			coef_new = COEF_MN;
		end else begin
			coef_new = COEF_MX;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && cordic_done) begin
			c_q   <= cos_val;
			s_q   <= sin_val;
			omc_q <= 33'(aapr_pkg::Q30_ONE) - 33'(cos_val);
		end
		if (state_q == ST_MUL1) begin
			pair_q <= axis_q[sel.a] * axis_q[sel.b];
			side_q <= sel.diag ? 48'(c_q) : axis_q[sel.t] * s_q;
		end
		if (state_q == ST_MUL2) begin
			prod_q  <= prod_full[63:0];
			extra_q <= (sel.neg ? -side_sh : side_sh) + HALF;
		end
	end

	assign coef = coef_q;

	a_write_starts_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_wr && cfg.payload.index <= aapr_pkg::REG_AXIS_Z) |=> busy)
		else $error("Register write did not start a coefficient rebuild");

	a_matrix_held_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !cfg_wr) |=> $stable(coef_q))
		else $error("Coefficients changed while no rebuild was running");

endmodule

// File: sv/aapr_mac.sv
// Three-stage matrix-vector pipeline: products, partial sums, then rounding
// and saturation into the output register. Uses aapr_pkg types.

module aapr_mac #(
	parameter int COEF_FRAC_BITS = aapr_pkg::COEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  aapr_pkg::point_t               point,
	input  logic [8:0][COEF_FRAC_BITS+1:0] coef,
	aapr_result_if.source                  rotated
);

	localparam int COEF_W = COEF_FRAC_BITS + 2;
	localparam int PROD_W = COEF_W + aapr_pkg::COORD_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SH_W   = SUM_W - COEF_FRAC_BITS;
	localparam int CW     = aapr_pkg::COORD_W;

	localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [CW-1:0]    OUT_MX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0]    OUT_MN = {1'b1, {(CW-1){1'b0}}};

	logic signed [CW-1:0]     p [3];
	logic signed [PROD_W-1:0] prod_s1 [3][3];
	logic signed [SUM_W-1:0]  sa_s2 [3];
	logic signed [SUM_W-1:0]  sb_s2 [3];
	logic signed [SUM_W-1:0]  acc [3];
	logic signed [SH_W-1:0]   sh [3];
	logic signed [CW-1:0]     val [3];
	logic [2:0]               hit;
	logic                     v_s1, v_s2, v_s3;
	logic                     en1, en2, en3;
	aapr_pkg::result_t        res_s3;

	assign p[0] = point.point_x;
	assign p[1] = point.point_y;
	assign p[2] = point.point_z;

	assign en3      = !v_s3 || rotated.ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = sa_s2[r] + sb_s2[r];
			sh[r]  = acc[r][SUM_W-1:COEF_FRAC_BITS];
			if (&sh[r][SH_W-1:CW-1] || ~|sh[r][SH_W-1:CW-1]) begin
				val[r] = sh[r][CW-1:0];
				hit[r] = 1'b0;
			end else begin
				val[r] = sh[r][SH_W-1] ? OUT_MN : OUT_MX;
				hit[r] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < 3; r++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[r][k] <= $signed(coef[r*3+k]) * p[k];
				end
			end
		end
		if (en2) begin
			for (int r = 0; r < 3; r++) begin
				sa_s2[r] <= SUM_W'(prod_s1[r][0]) + SUM_W'(prod_s1[r][1]);
				sb_s2[r] <= SUM_W'(prod_s1[r][2]) + HALF;
			end
		end
		if (en3) begin
			res_s3.rotated_x <= val[0];
			res_s3.rotated_y <= val[1];
			res_s3.rotated_z <= val[2];
			res_s3.saturated <= |hit;
		end
	end

	assign rotated.valid   = v_s3;
	assign rotated.payload = res_s3;

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.saturated) |->
			(res_s3.rotated_x == OUT_MX || res_s3.rotated_x == OUT_MN ||
			 res_s3.rotated_y == OUT_MX || res_s3.rotated_y == OUT_MN ||
			 res_s3.rotated_z == OUT_MX || res_s3.rotated_z == OUT_MN))
		else $error("Saturation flagged with no coordinate at a limit");

endmodule

// File: sv/axis_angle_point_rotator.sv
// Top level of the axis-angle point rotator: configuration and coefficient
// sequencer (aapr_coef) feeding the point pipeline (aapr_mac).
//
// Usage:
// The points channel takes one signed Q16.16 point per transfer and the
// rotated channel returns one rotated, rounded and saturated point per input
// point, in order. The cfg channel writes the angle (index 0) and the Q1.14
// axis components (indices 1 to 3); other indices are accepted and ignored.
// Each write to indices 0 to 3 starts a coefficient rebuild: a 24-step CORDIC
// for the sine and cosine, then the nine coefficients one after another
// through the MUL1, MUL2 and ACC states. During the rebuild both points and
// cfg hold ready low. The point pipeline has three register stages, so a
// result passes the product, partial-sum and output registers before it is
// offered; one point per cycle is sustained unless a rebuild or the receiver
// holds it. When the receiver stalls, the stages fill up and points.ready
// falls only once no stage can move. Reset empties the pipeline, sets the
// angle to zero and the axis to +z, and loads the identity matrix directly.

module axis_angle_point_rotator #(
	parameter int COEF_FRAC_BITS = aapr_pkg::COEF_FRAC_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	aapr_point_if.sink     points,
	aapr_result_if.source  rotated,
	aapr_cfg_if.sink       cfg
);

	logic                             busy;
	logic                             mac_ready;
	logic [8:0][COEF_FRAC_BITS+1:0]   coef;

	aapr_coef #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_coef (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.busy   (busy),
		.coef   (coef)
	);

	aapr_mac #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid && !busy),
		.in_ready (mac_ready),
		.point    (points.payload),
		.coef     (coef),
		.rotated  (rotated)
	);

	assign points.ready = mac_ready && !busy;

endmodule

// File: tb/tb_axis_angle_point_rotator.sv
// Self-checking testbench for axis_angle_point_rotator: directed and random points under
// a series of angle and axis settings, with a bit-exact rotation tracker as scoreboard.
// Depends on aapr_pkg and the channel interfaces in aapr_ifs.sv.

module tb_axis_angle_point_rotator;

	localparam int FRAC = aapr_pkg::COEF_FRAC_BITS;
	localparam int CW   = FRAC + 2;

	localparam logic [1:0] QUAD_I   = 2'd0;
	localparam logic [1:0] QUAD_II  = 2'd1;
	localparam logic [1:0] QUAD_III = 2'd2;
	localparam logic [1:0] QUAD_IV  = 2'd3;

	localparam logic [3:0] REG_UNUSED = 4'd15;

	localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

	localparam longint ATAN_STEP [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81
	};

	class rotation_tracker;
		logic [15:0]          angle;
		logic signed [15:0]   ax;
		logic signed [15:0]   ay;
		logic signed [15:0]   az;
		logic signed [CW-1:0] m [9];
		aapr_pkg::result_t    rotated_due [$];
		int                   errors;

		function new();
			angle = '0;
			ax = '0;
			ay = '0;
			az = 16'sd16384;
			for (int i = 0; i < 9; i++)
				m[i] = (i % 4 == 0) ? (CW'(1) << FRAC) : '0;
			errors = 0;
		endfunction

		function void cos_sin(output longint c, output longint s);
			longint x, y, z, dx, dy;
			x = 652032874;
			y = 0;
			z = {angle[13:0], 16'h0000};
			for (int i = 0; i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x = x - dx;
					y = y + dy;
					z = z - ATAN_STEP[i];
				end else begin
					x = x + dx;
					y = y - dy;
					z = z + ATAN_STEP[i];
				end
			end
			case (angle[15:14])
				QUAD_I: begin
					c = x;
					s = y;
				end
				QUAD_II: begin
					c = -y;
					s = x;
				end
				QUAD_III: begin
					c = -x;
					s = -y;
				end
				default: begin
					c = y;
					s = -x;
				end
			endcase
		endfunction

		function logic signed [CW-1:0] coef_round(longint v);
			longint r, hi;
			hi = (64'sd1 <<< (CW - 1)) - 1;
			r = (v + (64'sd1 <<< (57 - FRAC))) >>> (58 - FRAC);
			if (r > hi)
				r = hi;
			else if (r < -hi - 1)
				r = -hi - 1;
			return r[CW-1:0];
		endfunction

		function void rebuild();
			longint c, s, omc, x, y, z, cc;
			cos_sin(c, s);
			x = ax;
			y = ay;
			z = az;
			omc = (64'sd1 <<< 30) - c;
			cc = c <<< 28;
			m[0] = coef_round(x * x * omc + cc);
			m[1] = coef_round(x * y * omc + ((z * s) <<< 14));
			m[2] = coef_round(x * z * omc - ((y * s) <<< 14));
			m[3] = coef_round(x * y * omc - ((z * s) <<< 14));
			m[4] = coef_round(y * y * omc + cc);
			m[5] = coef_round(y * z * omc + ((x * s) <<< 14));
			m[6] = coef_round(x * z * omc + ((y * s) <<< 14));
			m[7] = coef_round(y * z * omc - ((x * s) <<< 14));
			m[8] = coef_round(z * z * omc + cc);
		endfunction

		function void write_reg(logic [3:0] idx, logic [15:0] val);
			case (idx)
				aapr_pkg::REG_ANGLE:  angle = val;
				aapr_pkg::REG_AXIS_X: ax = val;
				aapr_pkg::REG_AXIS_Y: ay = val;
				aapr_pkg::REG_AXIS_Z: az = val;
				default: return;
			endcase
			rebuild();
		endfunction

		function void note_point(aapr_pkg::point_t p);
			longint            pv [3];
			longint            acc;
			logic signed [31:0] outv [3];
			aapr_pkg::result_t e;
			pv[0] = $signed(p.point_x);
			pv[1] = $signed(p.point_y);
			pv[2] = $signed(p.point_z);
			e.saturated = 1'b0;
			for (int row = 0; row < 3; row++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc = acc + longint'(m[row * 3 + k]) * pv[k];
				acc = (acc + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
				if (acc > 64'sd2147483647) begin
					acc = 64'sd2147483647;
					e.saturated = 1'b1;
				end else if (acc < -64'sd2147483648) begin
					acc = -64'sd2147483648;
					e.saturated = 1'b1;
				end
				outv[row] = acc[31:0];
			end
			e.rotated_x = outv[0];
			e.rotated_y = outv[1];
			e.rotated_z = outv[2];
			rotated_due.push_back(e);
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(aapr_pkg::result_t got);
			aapr_pkg::result_t want;
			if (rotated_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d %0d %0d sat %0d",
					$time, got.rotated_x, got.rotated_y, got.rotated_z, got.saturated);
				errors++;
				return;
			end
			want = rotated_due.pop_front();
			compare_field("rotated_x", $signed(want.rotated_x), $signed(got.rotated_x));
			compare_field("rotated_y", $signed(want.rotated_y), $signed(got.rotated_y));
			compare_field("rotated_z", $signed(want.rotated_z), $signed(got.rotated_z));
			compare_field("saturated", want.saturated, got.saturated);
		endfunction

		function int pending();
			return rotated_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   calm;
	bit   hold_request;

	aapr_point_if  points_ch ();
	aapr_result_if rotated_ch ();
	aapr_cfg_if    cfg_ch ();

	rotation_tracker tracker = new();

	axis_angle_point_rotator uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.points  (points_ch),
		.rotated (rotated_ch),
		.cfg     (cfg_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[axis_angle_point_rotator] ERROR");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		rotated_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				rotated_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = 59;
				rotated_ch.ready <= 1'b0;
			end else begin
				rotated_ch.ready <= calm || ($urandom_range(0, 99) >= 11);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rotated_ch.valid && rotated_ch.ready)
			tracker.check_result(rotated_ch.payload);
	end

	function automatic aapr_pkg::point_t mk_point(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		aapr_pkg::point_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		return p;
	endfunction

	function automatic logic signed [31:0] rand_coord();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0: v = C_MAX;
			1: v = C_MIN;
			2, 3, 4: v = $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [15:0] rand_axis();
		logic [15:0] v;
		case ($urandom_range(0, 19))
			0: v = 16'h4000;
			1: v = 16'hC000;
			2: v = 16'h0000;
			3: v = 16'h7FFF;
			4: v = 16'h8000;
			5, 6: v = $urandom;
			default: v = 16'($urandom_range(0, 32768)) - 16'd16384;
		endcase
		return v;
	endfunction

	task automatic send_point(aapr_pkg::point_t p);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 11) begin
			points_ch.valid <= 1'b0;
			@(negedge clk);
		end
		points_ch.valid <= 1'b1;
		points_ch.payload <= p;
		do @(posedge clk); while (!points_ch.ready);
		tracker.note_point(p);
	endtask

	task automatic cfg_write(logic [3:0] idx, logic [15:0] val);
		aapr_pkg::cfg_t w;
		w.index = idx;
		w.value = val;
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= w;
		do @(posedge clk); while (!cfg_ch.ready);
		tracker.write_reg(idx, val);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		points_ch.valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int  n;
		bit  wrote;
		points_ch.valid = 1'b0;
		points_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		arst_n = 1'b0;
		calm = 1'b0;
		hold_request = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Identity matrix straight out of reset.
		send_point(mk_point(0, 0, 0));
		send_point(mk_point(C_MAX, C_MIN, -1));
		send_point(mk_point(C_MIN, C_MAX, 1));
		send_point(mk_point(32'sh0001_8000, -32'sh0000_8000, 32'sh1234_5678));
		drain();

		cfg_write(aapr_pkg::REG_ANGLE, 16'd16384);
		send_point(mk_point(32'sd65536, 0, 0));
		send_point(mk_point(0, 32'sd65536, 0));
		send_point(mk_point(C_MAX, C_MAX, C_MAX));
		drain();

		// A write to an unused index must leave the matrix alone.
		cfg_write(REG_UNUSED, 16'hFFFF);
		send_point(mk_point(1, -1, 32'sd65536));
		drain();

		// Axis of length sqrt(3) at half a turn: coefficients above one, outputs clamp.
		cfg_write(aapr_pkg::REG_AXIS_X, 16'h4000);
		cfg_write(aapr_pkg::REG_AXIS_Y, 16'h4000);
		cfg_write(aapr_pkg::REG_ANGLE, 16'd32768);
		send_point(mk_point(C_MAX, C_MAX, C_MAX));
		send_point(mk_point(C_MIN, C_MIN, C_MIN));
		send_point(mk_point(1, 2, 3));
		send_point(mk_point(C_MAX, 0, 0));
		drain();

		// Extreme axis values with an angle just short of a full turn.
		cfg_write(aapr_pkg::REG_AXIS_X, 16'h8000);
		cfg_write(aapr_pkg::REG_AXIS_Y, 16'h7FFF);
		cfg_write(aapr_pkg::REG_AXIS_Z, 16'h0000);
		cfg_write(aapr_pkg::REG_ANGLE, 16'hFFFF);
		send_point(mk_point(C_MAX, C_MIN, 0));
		send_point(mk_point(32'sd65536, 32'sd65536, 32'sd65536));
		drain();

		cfg_write(aapr_pkg::REG_ANGLE, 16'd0);
		cfg_write(aapr_pkg::REG_AXIS_X, 16'h0000);
		cfg_write(aapr_pkg::REG_AXIS_Y, 16'h0000);
		cfg_write(aapr_pkg::REG_AXIS_Z, 16'hC000);
		send_point(mk_point(-32'sd65536, 32'sd98304, C_MIN));
		drain();

		cfg_write(aapr_pkg::REG_ANGLE, 16'd49152);
		send_point(mk_point(32'sd65536, -32'sd65536, 7));

		for (int ph = 0; ph < 12; ph++) begin
			drain();
			wrote = 1'b0;
			if ($urandom_range(0, 1)) begin
				case ($urandom_range(0, 5))
					0: cfg_write(aapr_pkg::REG_ANGLE, 16'd0);
					1: cfg_write(aapr_pkg::REG_ANGLE, 16'hFFFF);
					2: cfg_write(aapr_pkg::REG_ANGLE, 16'(16384 * $urandom_range(1, 3)));
					default: cfg_write(aapr_pkg::REG_ANGLE, 16'($urandom));
				endcase
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				cfg_write(aapr_pkg::REG_AXIS_X, rand_axis());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				cfg_write(aapr_pkg::REG_AXIS_Y, rand_axis());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				cfg_write(aapr_pkg::REG_AXIS_Z, rand_axis());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 3) == 0)
				cfg_write(4'($urandom_range(aapr_pkg::REG_AXIS_Z + 1, REG_UNUSED)), 16'($urandom));
			if (!wrote)
				cfg_write(aapr_pkg::REG_ANGLE, 16'($urandom));
			if (ph == 3)
				hold_request = 1'b1;
			calm = (ph == 7);
			n = $urandom_range(50, 75);
			repeat (n)
				send_point(mk_point(rand_coord(), rand_coord(), rand_coord()));
		end

		drain();
		calm = 1'b0;
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("[axis_angle_point_rotator] OK");
		else
			$display("[axis_angle_point_rotator] ERROR");
		$finish;
	end

endmodule

// File: sim.f
sv/aapr_pkg.sv
sv/aapr_ifs.sv
sv/aapr_cordic.sv
sv/aapr_coef.sv
sv/aapr_mac.sv
sv/axis_angle_point_rotator.sv
tb/tb_axis_angle_point_rotator.sv
